@@ hw/rtl/cartesian_to_azimuth_range_unit_assert.svh @@
// Assertion macros for the Cartesian to azimuth and range converter.
`ifndef CARTESIAN_TO_AZIMUTH_RANGE_UNIT_ASSERT_SVH
`define CARTESIAN_TO_AZIMUTH_RANGE_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled in reset.
`define C2AR_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled in reset.
`define C2AR_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/c2ar_pkg.sv @@
// Shared types and constants of the Cartesian to azimuth and range converter.
package c2ar_pkg;

  localparam int RANGE_WIDTH      = 24;
  localparam int TURN_WIDTH       = 32;
  localparam int PRESCALE_SHIFT   = 8;
  localparam int MAX_CORDIC_STEPS = 32;

  typedef logic [TURN_WIDTH-1:0] turn_t;

  localparam logic [RANGE_WIDTH-1:0] RANGE_MAX = '1;
  localparam turn_t TURN_HALF = 32'h8000_0000;

  // The value atan(2^-i) as a fraction of a full turn, rounded to nearest.
  localparam turn_t ATAN_TURN [MAX_CORDIC_STEPS] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861,
    32'd10430,     32'd5215,      32'd2608,      32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81,
    32'd41,        32'd20,        32'd10,        32'd5,
    32'd3,         32'd1,         32'd1,         32'd0
  };

endpackage

@@ hw/rtl/c2ar_in_if.sv @@
// Input channel carrying one pair of Cartesian coordinates per transfer.
interface c2ar_in_if #(
  parameter int COORD_WIDTH = 24
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] x_metres;
  logic signed [COORD_WIDTH-1:0] y_metres;

  modport source (output valid, output x_metres, output y_metres, input ready);
  modport sink (input valid, input x_metres, input y_metres, output ready);
endinterface

@@ hw/rtl/c2ar_out_if.sv @@
// Result channel carrying one range and azimuth pair per transfer.
interface c2ar_out_if
  import c2ar_pkg::*;
#(
  parameter int ANGLE_WIDTH = 16
);
  logic                   valid;
  logic                   ready;
  logic [RANGE_WIDTH-1:0] range_metres;
  logic [ANGLE_WIDTH-1:0] azimuth_turn;

  modport source (output valid, output range_metres, output azimuth_turn, input ready);
  modport sink (input valid, input range_metres, input azimuth_turn, output ready);
endinterface

@@ hw/rtl/c2ar_stage.sv @@
// One pipeline stage: a CORDIC rotation or pass next to a square, sum, root-bit or pass step.
module c2ar_stage
  import c2ar_pkg::*;
#(
  parameter int COORD_WIDTH  = 24,
  parameter int CORDIC_STEPS = 18,
  parameter int STAGE        = 1,
  localparam int SUM_W       = 2 * COORD_WIDTH,
  localparam int VEC_W       = COORD_WIDTH + PRESCALE_SHIFT + 3
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    adv,
  input  logic                    vld_in,
  output logic                    vld_r,
  input  logic [SUM_W-1:0]        p_in,
  input  logic [SUM_W-1:0]        q_in,
  input  logic [COORD_WIDTH-1:0]  root_in,
  input  logic signed [VEC_W-1:0] a_in,
  input  logic signed [VEC_W-1:0] b_in,
  input  turn_t                   z_in,
  output logic [SUM_W-1:0]        p_r,
  output logic [SUM_W-1:0]        q_r,
  output logic [COORD_WIDTH-1:0]  root_r,
  output logic signed [VEC_W-1:0] a_r,
  output logic signed [VEC_W-1:0] b_r,
  output turn_t                   z_r
);

  localparam int ROT      = STAGE - 1;
  localparam int BIT_STEP = STAGE - 3;
  localparam int BIT_POS  = COORD_WIDTH - 1 - BIT_STEP;

  logic [SUM_W-1:0]        p_nxt;
  logic [SUM_W-1:0]        q_nxt;
  logic [COORD_WIDTH-1:0]  root_nxt;
  logic signed [VEC_W-1:0] a_nxt;
  logic signed [VEC_W-1:0] b_nxt;
  turn_t                   z_nxt;

  generate
    if (STAGE == 1) begin : g_square
      always_comb begin
        p_nxt    = SUM_W'(p_in[COORD_WIDTH-1:0]) * SUM_W'(p_in[COORD_WIDTH-1:0]);
        q_nxt    = SUM_W'(q_in[COORD_WIDTH-1:0]) * SUM_W'(q_in[COORD_WIDTH-1:0]);
        root_nxt = '0;
      end
    end else if (STAGE == 2) begin : g_sum
      always_comb begin
        p_nxt    = p_in + q_in;
        q_nxt    = '0;
        root_nxt = '0;
      end
    end else if (BIT_STEP < COORD_WIDTH) begin : g_root
      // The remainder holds the radicand minus the square of the partial root.
      logic [SUM_W-1:0] trial;
      always_comb begin
        trial    = (SUM_W'(root_in) << (BIT_POS + 1)) | (SUM_W'(1) << (2 * BIT_POS));
        q_nxt    = '0;
        p_nxt    = p_in;
        root_nxt = root_in;
        if (p_in >= trial) begin
          p_nxt    = p_in - trial;
          root_nxt = root_in | (COORD_WIDTH'(1) << BIT_POS);
        end
      end
    end else begin : g_root_pass
      always_comb begin
        p_nxt    = p_in;
        q_nxt    = '0;
        root_nxt = root_in;
      end
    end

    if (ROT < CORDIC_STEPS) begin : g_rotate
      logic signed [VEC_W-1:0] a_sh;
      logic signed [VEC_W-1:0] b_sh;
      always_comb begin
        a_sh  = a_in >>> ROT;
        b_sh  = b_in >>> ROT;
        a_nxt = a_in;
        b_nxt = b_in;
        z_nxt = z_in;
        if (!b_in[VEC_W-1] && (b_in != '0)) begin
          a_nxt = a_in + b_sh;
          b_nxt = b_in - a_sh;
          z_nxt = z_in + ATAN_TURN[ROT];
        end else if (b_in[VEC_W-1]) begin
          a_nxt = a_in - b_sh;
          b_nxt = b_in + a_sh;
          z_nxt = z_in - ATAN_TURN[ROT];
        end
      end
    end else begin : g_rotate_pass
      always_comb begin
        a_nxt = a_in;
        b_nxt = b_in;
        z_nxt = z_in;
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p_r    <= p_nxt;
      q_r    <= q_nxt;
      root_r <= root_nxt;
      a_r    <= a_nxt;
      b_r    <= b_nxt;
      z_r    <= z_nxt;
    end
  end

endmodule

@@ hw/rtl/cartesian_to_azimuth_range_unit.sv @@
// Pipelined Cartesian to azimuth and range converter (CORDIC and root per bit).
// A pair passes the input register, the stage chain and the output register in order.
// Throughput is one transfer per cycle; the root pipeline resolves one bit per stage.
// The whole pipeline advances while the output skid register is empty.
// Synchronous active-low reset clears all valid bits; payload registers are not reset.
`include "cartesian_to_azimuth_range_unit_assert.svh"

module cartesian_to_azimuth_range_unit
  import c2ar_pkg::*;
#(
  parameter int COORD_WIDTH  = 24,
  parameter int ANGLE_WIDTH  = 16,
  parameter int CORDIC_STEPS = 18
) (
  input logic        clk,
  input logic        rst_n,
  c2ar_in_if.sink    in_ch,
  c2ar_out_if.source out_ch
);

  localparam int SUM_W = 2 * COORD_WIDTH;
  localparam int VEC_W = COORD_WIDTH + PRESCALE_SHIFT + 3;
  localparam int NSTG  = 3 + ((COORD_WIDTH > CORDIC_STEPS - 2) ? COORD_WIDTH : CORDIC_STEPS - 2);
  localparam int LAST  = NSTG - 1;
  localparam int RW    = (COORD_WIDTH > RANGE_WIDTH) ? COORD_WIDTH : RANGE_WIDTH;

  logic                    adv;
  logic                    vld_s  [NSTG];
  logic [SUM_W-1:0]        p_s    [NSTG];
  logic [SUM_W-1:0]        q_s    [NSTG];
  logic [COORD_WIDTH-1:0]  root_s [NSTG];
  logic signed [VEC_W-1:0] a_s    [NSTG];
  logic signed [VEC_W-1:0] b_s    [NSTG];
  turn_t                   z_s    [NSTG];

  logic                    vld0_r;
  logic [COORD_WIDTH-1:0]  ax0_r;
  logic [COORD_WIDTH-1:0]  ay0_r;
  logic signed [VEC_W-1:0] a0_r;
  logic signed [VEC_W-1:0] b0_r;
  turn_t                   z0_r;

  logic [COORD_WIDTH-1:0]  ax_nxt;
  logic [COORD_WIDTH-1:0]  ay_nxt;
  logic signed [VEC_W-1:0] a_nxt;
  logic signed [VEC_W-1:0] b_nxt;
  turn_t                   z_nxt;

  logic                    out_vld_r;
  logic                    out_vld_nxt;
  logic [RANGE_WIDTH-1:0]  out_range_r;
  logic [ANGLE_WIDTH-1:0]  out_az_r;
  logic                    skid_vld_r;
  logic                    skid_vld_nxt;
  logic [RANGE_WIDTH-1:0]  skid_range_r;
  logic [ANGLE_WIDTH-1:0]  skid_az_r;
  logic                    out_free;
  logic                    push;
  logic                    out_load;
  logic                    skid_load;
  logic [RW-1:0]           root_ext;
  logic [RANGE_WIDTH-1:0]  range_sat;
  logic [ANGLE_WIDTH-1:0]  az_cut;

  assign adv         = !skid_vld_r;
  assign in_ch.ready = adv;

  // The working pair is (north, east); a southern point is turned half a turn first.
  always_comb begin
    ax_nxt = in_ch.x_metres[COORD_WIDTH-1] ? COORD_WIDTH'(~in_ch.x_metres + 1'b1)
                                           : COORD_WIDTH'(in_ch.x_metres);
    ay_nxt = in_ch.y_metres[COORD_WIDTH-1] ? COORD_WIDTH'(~in_ch.y_metres + 1'b1)
                                           : COORD_WIDTH'(in_ch.y_metres);
    a_nxt  = VEC_W'(in_ch.y_metres) <<< PRESCALE_SHIFT;
    b_nxt  = VEC_W'(in_ch.x_metres) <<< PRESCALE_SHIFT;
    z_nxt  = '0;
    if (in_ch.y_metres[COORD_WIDTH-1]) begin
      a_nxt = -(VEC_W'(in_ch.y_metres) <<< PRESCALE_SHIFT);
      b_nxt = -(VEC_W'(in_ch.x_metres) <<< PRESCALE_SHIFT);
      z_nxt = TURN_HALF;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld0_r <= 1'b0;
    end else if (adv) begin
      vld0_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ax0_r <= ax_nxt;
      ay0_r <= ay_nxt;
      a0_r  <= a_nxt;
      b0_r  <= b_nxt;
      z0_r  <= z_nxt;
    end
  end

  assign vld_s[0]  = vld0_r;
  assign p_s[0]    = SUM_W'(ax0_r);
  assign q_s[0]    = SUM_W'(ay0_r);
  assign root_s[0] = '0;
  assign a_s[0]    = a0_r;
  assign b_s[0]    = b0_r;
  assign z_s[0]    = z0_r;

  generate
    for (genvar s = 1; s < NSTG; s++) begin : g_stage
      c2ar_stage #(
        .COORD_WIDTH  (COORD_WIDTH),
        .CORDIC_STEPS (CORDIC_STEPS),
        .STAGE        (s)
      ) u_stage (
        .clk     (clk),
        .rst_n   (rst_n),
        .adv     (adv),
        .vld_in  (vld_s[s-1]),
        .vld_r   (vld_s[s]),
        .p_in    (p_s[s-1]),
        .q_in    (q_s[s-1]),
        .root_in (root_s[s-1]),
        .a_in    (a_s[s-1]),
        .b_in    (b_s[s-1]),
        .z_in    (z_s[s-1]),
        .p_r     (p_s[s]),
        .q_r     (q_s[s]),
        .root_r  (root_s[s]),
        .a_r     (a_s[s]),
        .b_r     (b_s[s]),
        .z_r     (z_s[s])
      );
    end
  endgenerate

  always_comb begin
    root_ext  = RW'(root_s[LAST]);
    range_sat = root_ext[RANGE_WIDTH-1:0];
    if (root_ext > RW'(RANGE_MAX)) begin
      range_sat = RANGE_MAX;
    end
    az_cut = z_s[LAST][TURN_WIDTH-1 -: ANGLE_WIDTH];
  end

  // A result that finds the output register busy parks in the skid register.
  always_comb begin
    out_free     = !out_vld_r || out_ch.ready;
    push         = adv && vld_s[LAST];
    out_load     = out_free && (skid_vld_r || push);
    out_vld_nxt  = out_free ? (skid_vld_r || push) : 1'b1;
    skid_load    = push && !out_free;
    skid_vld_nxt = skid_load ? 1'b1 : (out_free ? 1'b0 : skid_vld_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      out_vld_r  <= out_vld_nxt;
      skid_vld_r <= skid_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_range_r <= skid_vld_r ? skid_range_r : range_sat;
      out_az_r    <= skid_vld_r ? skid_az_r : az_cut;
    end
    if (skid_load) begin
      skid_range_r <= range_sat;
      skid_az_r    <= az_cut;
    end
  end

  assign out_ch.valid        = out_vld_r;
  assign out_ch.range_metres = out_range_r;
  assign out_ch.azimuth_turn = out_az_r;

  `C2AR_ASSERT_IMP(a_skid_behind_out, skid_vld_r, out_vld_r, "skid register full while output register empty")
  `C2AR_ASSERT_NXT(a_stall_keeps_out, !in_ch.ready, out_vld_r, "output register emptied during a stall")
  `C2AR_ASSERT_IMP(a_root_remainder, vld_s[LAST], p_s[LAST] <= (SUM_W'(root_s[LAST]) << 1), "square root remainder out of range")
  `C2AR_ASSERT_IMP(a_origin_azimuth, out_vld_r && (out_range_r == '0), out_az_r == '0, "zero range with nonzero azimuth")

endmodule

@@ bench/tb_top.sv @@
// Testbench for the Cartesian to azimuth and range converter under directed and random traffic.
`timescale 1ns / 100ps

module tb_top;
  import c2ar_pkg::*;

  localparam int COORD_W     = 24;
  localparam int ANGLE_W     = 16;
  localparam int STEPS       = 18;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_WAIT  = 60;
  localparam int MAX_SHOWN   = 10;

  localparam logic signed [COORD_W-1:0] C_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic signed [COORD_W-1:0] C_MIN = {1'b1, {(COORD_W-1){1'b0}}};

  typedef enum logic [2:0] {
    PH_STEADY,
    PH_SEND_IDLE,
    PH_RECV_STALL,
    PH_BOTH_IDLE,
    PH_HOLD
  } phase_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
  } coord_pair_t;

  typedef struct packed {
    logic [RANGE_WIDTH-1:0] range_metres;
    logic [ANGLE_W-1:0]     azimuth_turn;
  } polar_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  c2ar_in_if #(.COORD_WIDTH(COORD_W)) in_ch ();
  c2ar_out_if #(.ANGLE_WIDTH(ANGLE_W)) out_ch ();

  cartesian_to_azimuth_range_unit #(
    .COORD_WIDTH (COORD_W),
    .ANGLE_WIDTH (ANGLE_W),
    .CORDIC_STEPS(STEPS)
  ) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  coord_pair_t pending_coords[$];
  polar_t      expected_polar[$];
  coord_pair_t next_pair;
  phase_t      phase = PH_STEADY;
  int          hold_left;
  logic        hold_done;
  int          mismatch_count = 0;

  always #6 clk = ~clk;

  function automatic polar_t polar_of(input logic signed [COORD_W-1:0] x,
                                      input logic signed [COORD_W-1:0] y);
    polar_t            res;
    longint unsigned   sq;
    longint unsigned   cand;
    logic [RANGE_WIDTH-1:0] root;
    longint            a;
    longint            b;
    longint            da;
    longint            db;
    turn_t             z;
    sq = longint'(x) * longint'(x) + longint'(y) * longint'(y);
    root = '0;
    for (int k = RANGE_WIDTH - 1; k >= 0; k--) begin
      cand = root | (64'd1 << k);
      if (cand * cand <= sq) begin
        root = cand[RANGE_WIDTH-1:0];
      end
    end
    a = longint'(y) * (longint'(1) << PRESCALE_SHIFT);
    b = longint'(x) * (longint'(1) << PRESCALE_SHIFT);
    z = '0;
    if (a < 0) begin
      a = -a;
      b = -b;
      z = TURN_HALF;
    end
    for (int i = 0; i < STEPS && i < MAX_CORDIC_STEPS; i++) begin
      da = b >>> i;
      db = a >>> i;
      if (b > 0) begin
        a = a + da;
        b = b - db;
        z = z + ATAN_TURN[i];
      end else if (b < 0) begin
        a = a - da;
        b = b + db;
        z = z - ATAN_TURN[i];
      end
    end
    res.range_metres = root;
    res.azimuth_turn = z[TURN_WIDTH-1 -: ANGLE_W];
    return res;
  endfunction

  function automatic logic signed [COORD_W-1:0] rand_coord(input int shape);
    logic signed [COORD_W-1:0] v;
    v = COORD_W'($urandom());
    case (shape)
      0: begin
        v = COORD_W'($urandom_range(64)) - COORD_W'(32);
      end
      1: begin
        v = v >>> $urandom_range(COORD_W - 1);
      end
      2: begin
        case ($urandom_range(4))
          0: v = C_MIN;
          1: v = C_MAX;
          2: v = '1;
          3: v = '0;
          default: v = COORD_W'(1);
        endcase
      end
      default: begin
      end
    endcase
    return v;
  endfunction

  task automatic add_pair(input logic signed [COORD_W-1:0] x,
                          input logic signed [COORD_W-1:0] y);
    coord_pair_t p;
    p.x = x;
    p.y = y;
    pending_coords.push_back(p);
  endtask

  task automatic add_random(input int count);
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    for (int n = 0; n < count; n++) begin
      case ($urandom_range(9))
        0, 1, 2, 3: begin
          x = rand_coord(3);
          y = rand_coord(3);
        end
        4: begin
          x = rand_coord(0);
          y = rand_coord(0);
        end
        5: begin
          x = rand_coord(3);
          y = '0;
          if ($urandom_range(1)) begin
            y = x;
            x = '0;
          end
        end
        6: begin
          x = COORD_W'($urandom_range(6)) - COORD_W'(3);
          y = rand_coord(1);
          if ($urandom_range(1)) begin
            y = x;
            x = rand_coord(1);
          end
        end
        7: begin
          x = rand_coord(1);
          y = $urandom_range(1) ? x : -x;
        end
        8: begin
          x = rand_coord(2);
          y = rand_coord(2);
        end
        default: begin
          x = rand_coord(1);
          y = rand_coord(1);
        end
      endcase
      add_pair(x, y);
    end
  endtask

  function automatic logic sender_pauses();
    case (phase)
      PH_SEND_IDLE: return $urandom_range(99) < 54;
      PH_BOTH_IDLE: return $urandom_range(99) < 13;
      default:      return 1'b0;
    endcase
  endfunction

  function automatic logic receiver_stalls();
    case (phase)
      PH_RECV_STALL: return $urandom_range(99) < 54;
      PH_BOTH_IDLE:  return $urandom_range(99) < 13;
      default:       return 1'b0;
    endcase
  endfunction

  task automatic flag_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_SHOWN) begin
      $display("mismatch at %0t: %s", $realtime, msg);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        expected_polar.push_back(polar_of(in_ch.x_metres, in_ch.y_metres));
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_coords.size() != 0 && !sender_pauses()) begin
          next_pair = pending_coords.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.x_metres <= next_pair.x;
          in_ch.y_metres <= next_pair.y;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (phase == PH_HOLD && !hold_done) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin
    polar_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_polar.size() == 0) begin
          flag_mismatch($sformatf("unexpected transfer range %0d azimuth %0d",
                                  out_ch.range_metres, out_ch.azimuth_turn));
        end else begin
          want = expected_polar.pop_front();
          if (out_ch.range_metres !== want.range_metres) begin
            flag_mismatch($sformatf("range expected %0d actual %0d",
                                    want.range_metres, out_ch.range_metres));
          end
          if (out_ch.azimuth_turn !== want.azimuth_turn) begin
            flag_mismatch($sformatf("azimuth expected %0d actual %0d",
                                    want.azimuth_turn, out_ch.azimuth_turn));
          end
        end
      end
      out_ch.ready <= (hold_left == 0) && !receiver_stalls();
    end
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.x_metres = '0;
    in_ch.y_metres = '0;
    out_ch.ready = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Origin, the four exact axes, the corners of the input range, small pairs and mixed extremes.
    add_pair('0, '0);
    add_pair('0, COORD_W'(1));
    add_pair(COORD_W'(1), '0);
    add_pair('0, '1);
    add_pair('1, '0);
    add_pair('0, C_MAX);
    add_pair(C_MAX, '0);
    add_pair('0, C_MIN);
    add_pair(C_MIN, '0);
    add_pair(C_MAX, C_MAX);
    add_pair(C_MIN, C_MIN);
    add_pair(C_MAX, C_MIN);
    add_pair(C_MIN, C_MAX);
    add_pair(COORD_W'(1), COORD_W'(1));
    add_pair('1, '1);
    add_pair(COORD_W'(1), '1);
    add_pair('1, COORD_W'(1));
    add_pair(-COORD_W'(5), '0);
    add_pair('0, -COORD_W'(5));
    add_pair(COORD_W'(3), COORD_W'(4));
    add_pair(-COORD_W'(3), -COORD_W'(4));
    add_pair(C_MAX, COORD_W'(1));
    add_pair(COORD_W'(1), C_MIN);
    add_pair(C_MIN, '1);
    add_random(300);
    wait (pending_coords.size() == 0);

    phase <= PH_SEND_IDLE;
    add_random(250);
    wait (pending_coords.size() == 0);

    phase <= PH_RECV_STALL;
    add_random(250);
    wait (pending_coords.size() == 0);

    phase <= PH_BOTH_IDLE;
    add_random(250);
    wait (pending_coords.size() == 0);

    phase <= PH_HOLD;
    add_random(300);
    wait (pending_coords.size() == 0 && !in_ch.valid);
    wait (expected_polar.size() == 0);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (mismatch_count == 0 && expected_polar.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #(12 * 200000);
    $display("TB_ERROR");
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/c2ar_pkg.sv
hw/rtl/c2ar_in_if.sv
hw/rtl/c2ar_out_if.sv
hw/rtl/c2ar_stage.sv
hw/rtl/cartesian_to_azimuth_range_unit.sv
bench/tb_top.sv
